// ===== design/psi_pkg.sv =====
`timescale 1ns / 1ps

package psi_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_GRID_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_START   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_COUNT = 3'd5;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_EVAL  = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    typedef enum logic [25:0] {
        S_IDLE = 26'h0000001,
        S_H2M  = 26'h0000002,
        S_H2R  = 26'h0000004,
        S_FRD  = 26'h0000008,
        S_FMUL = 26'h0000010,
        S_FD   = 26'h0000020,
        S_FB   = 26'h0000040,
        S_FV   = 26'h0000080,
        S_FN   = 26'h0000100,
        S_FDS  = 26'h0000200,
        S_FDW  = 26'h0000400,
        S_FW   = 26'h0000800,
        S_BRD  = 26'h0001000,
        S_BN   = 26'h0002000,
        S_BDS  = 26'h0004000,
        S_BDW  = 26'h0008000,
        S_BW   = 26'h0010000,
        S_ES   = 26'h0020000,
        S_EM   = 26'h0040000,
        S_EI   = 26'h0080000,
        S_ERA  = 26'h0100000,
        S_ERB  = 26'h0200000,
        S_ED   = 26'h0400000,
        S_EP   = 26'h0800000,
        S_EF   = 26'h1000000,
        S_OUT  = 26'h2000000
    } t_state;

    typedef enum logic [1:0] {
        CLS_LEFT   = 2'd0,
        CLS_RIGHT  = 2'd1,
        CLS_NODE   = 2'd2,
        CLS_INTERP = 2'd3
    } t_cls;

    typedef struct packed {
        t_state step;
        logic   accept;
    } t_cmd;

    typedef struct packed {
        logic k_last;
        logic k_one;
        logic div_done;
        t_cls cls;
        logic out_free;
    } t_stat;

endpackage

// ===== design/psi_if.sv =====
`timescale 1ns / 1ps

interface psi_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [9:0]         sample_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] query_position;

    modport source (output valid, command, sample_index, sample_value, query_position,
                    input ready);
    modport sink   (input valid, command, sample_index, sample_value, query_position,
                    output ready);
endinterface

interface psi_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               solve_done;

    modport source (output valid, result_value, solve_done, input ready);
    modport sink   (input valid, result_value, solve_done, output ready);
endinterface

// ===== design/psi_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle.
module psi_div #(
    parameter int DW = 46,
    parameter int NW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   r_q;
    logic [NW-1:0]   r_r;
    logic [NW-1:0]   r_d;
    logic [CNTW-1:0] r_cnt;
    logic            r_done;
    logic [NW:0]     n_trial;

    assign n_trial = {r_r, r_q[DW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNTW'(1));
            if (i_start) begin
                r_cnt <= CNTW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_cnt != '0) begin
            if (n_trial >= {1'b0, r_d}) begin
                r_r <= NW'(n_trial - {1'b0, r_d});
                r_q <= {r_q[DW-2:0], 1'b1};
            end else begin
                r_r <= n_trial[NW-1:0];
                r_q <= {r_q[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// ===== design/psi_ctrl.sv =====
`timescale 1ns / 1ps

module psi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_command,
    input  psi_pkg::t_stat i_stat,
    output logic           o_ready,
    output psi_pkg::t_cmd  o_cmd
);
    psi_pkg::t_state r_state;
    psi_pkg::t_state n_state;
    logic            n_accept;

    assign o_ready  = (r_state == psi_pkg::S_IDLE);
    assign n_accept = o_ready && i_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            psi_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        psi_pkg::CMD_SOLVE: n_state = psi_pkg::S_H2M;
                        psi_pkg::CMD_EVAL:  n_state = psi_pkg::S_ES;
                        default:            n_state = psi_pkg::S_IDLE;
                    endcase
                end
            end
            psi_pkg::S_H2M:  n_state = psi_pkg::S_H2R;
            psi_pkg::S_H2R:  n_state = psi_pkg::S_FRD;
            psi_pkg::S_FRD:  n_state = psi_pkg::S_FMUL;
            psi_pkg::S_FMUL: n_state = psi_pkg::S_FD;
            psi_pkg::S_FD:   n_state = psi_pkg::S_FB;
            psi_pkg::S_FB:   n_state = psi_pkg::S_FV;
            psi_pkg::S_FV:   n_state = psi_pkg::S_FN;
            psi_pkg::S_FN:   n_state = psi_pkg::S_FDS;
            psi_pkg::S_FDS:  n_state = psi_pkg::S_FDW;
            psi_pkg::S_FDW: begin
                if (i_stat.div_done) n_state = psi_pkg::S_FW;
            end
            psi_pkg::S_FW: begin
                n_state = i_stat.k_last ? psi_pkg::S_BRD : psi_pkg::S_FRD;
            end
            psi_pkg::S_BRD:  n_state = psi_pkg::S_BN;
            psi_pkg::S_BN:   n_state = psi_pkg::S_BDS;
            psi_pkg::S_BDS:  n_state = psi_pkg::S_BDW;
            psi_pkg::S_BDW: begin
                if (i_stat.div_done) n_state = psi_pkg::S_BW;
            end
            psi_pkg::S_BW: begin
                n_state = i_stat.k_one ? psi_pkg::S_OUT : psi_pkg::S_BRD;
            end
            psi_pkg::S_ES:   n_state = psi_pkg::S_EM;
            psi_pkg::S_EM:   n_state = psi_pkg::S_EI;
            psi_pkg::S_EI: begin
                if (i_stat.cls == psi_pkg::CLS_LEFT || i_stat.cls == psi_pkg::CLS_RIGHT) begin
                    n_state = psi_pkg::S_OUT;
                end else begin
                    n_state = psi_pkg::S_ERA;
                end
            end
            psi_pkg::S_ERA:  n_state = psi_pkg::S_ERB;
            psi_pkg::S_ERB:  n_state = psi_pkg::S_ED;
            psi_pkg::S_ED: begin
                n_state = (i_stat.cls == psi_pkg::CLS_NODE) ? psi_pkg::S_OUT : psi_pkg::S_EP;
            end
            psi_pkg::S_EP:   n_state = psi_pkg::S_EF;
            psi_pkg::S_EF:   n_state = psi_pkg::S_OUT;
            psi_pkg::S_OUT: begin
                if (i_stat.out_free) n_state = psi_pkg::S_IDLE;
            end
            default:         n_state = psi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.step   = r_state;
    assign o_cmd.accept = n_accept;
endmodule

// ===== design/psi_dp.sv =====
`timescale 1ns / 1ps

module psi_dp #(
    parameter int MAX_NODES = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  psi_pkg::t_cmd                  i_cmd,
    input  logic                           i_cfg_we,
    input  logic [psi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]                     i_command,
    input  logic [9:0]                     i_sample_index,
    input  logic signed [31:0]             i_sample_value,
    input  logic signed [31:0]             i_query_position,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic signed [31:0]             o_result_value,
    output logic                           o_solve_done,
    output psi_pkg::t_stat                 o_stat
);
    localparam int AW   = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 2);
    localparam int NUMW = 33 + CW;
    localparam int DW   = NUMW + 1;
    localparam int HW   = 64 - 2 * FRAC_BITS;
    localparam int PW   = 34 + FRAC_BITS;
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > SAT_HI) return 32'sh7fffffff;
        if (v < SAT_LO) return 32'sh80000000;
        return v[31:0];
    endfunction

    // round(v / 2^FRAC_BITS), ties away from zero
    function automatic logic signed [65:0] shr_round(input logic signed [65:0] v);
        logic [65:0] mg;
        logic [65:0] rd;
        mg = v[65] ? 66'(-v) : 66'(v);
        rd = (mg + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[65] ? -$signed(rd) : $signed(rd);
    endfunction

    // configuration
    logic [30:0]        r_grid;
    logic [30:0]        r_inv;
    logic signed [31:0] r_bl;
    logic signed [31:0] r_br;
    logic signed [31:0] r_ds;
    logic [10:0]        r_ic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= 31'd65536;
            r_inv  <= 31'd65536;
            r_bl   <= '0;
            r_br   <= '0;
            r_ds   <= '0;
            r_ic   <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psi_pkg::REG_GRID_STEP:      r_grid <= i_cfg_data[30:0];
                psi_pkg::REG_INV_GRID_STEP:  r_inv  <= i_cfg_data[30:0];
                psi_pkg::REG_BOUNDARY_LEFT:  r_bl   <= i_cfg_data;
                psi_pkg::REG_BOUNDARY_RIGHT: r_br   <= i_cfg_data;
                psi_pkg::REG_DOMAIN_START:   r_ds   <= i_cfg_data;
                psi_pkg::REG_INTERIOR_COUNT: r_ic   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // interior nodes in use, clamped to [2, MAX_NODES]
    logic [31:0]   n_ic32;
    logic [CW-1:0] n_m;
    always_comb begin
        n_ic32 = 32'(r_ic);
        if (n_ic32 < 32'd2) n_ic32 = 32'd2;
        if (n_ic32 > 32'(MAX_NODES)) n_ic32 = 32'(MAX_NODES);
        n_m = n_ic32[CW-1:0];
    end

    // node store
    logic signed [31:0] r_mem [MAX_NODES];
    logic signed [31:0] r_rdata;
    logic [AW-1:0]      n_raddr;
    logic [AW-1:0]      n_waddr;
    logic signed [31:0] n_wdata;
    logic               n_we;

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        r_rdata <= r_mem[n_raddr];
    end

    // datapath registers
    logic [CW-1:0]        r_k;
    logic [61:0]          r_h2p;
    logic [30:0]          r_h2;
    logic signed [63:0]   r_p;
    logic signed [31:0]   r_d;
    logic signed [32:0]   r_v;
    logic [NUMW-1:0]      r_num;
    logic                 r_neg;
    logic signed [31:0]   r_prev;
    logic signed [31:0]   r_a;
    logic signed [31:0]   r_z;
    logic signed [32:0]   r_zz;
    logic                 r_zneg;
    logic [63:0]          r_pm;
    logic [AW-1:0]        r_idx;
    logic [FRAC_BITS-1:0] r_frac;
    psi_pkg::t_cls        r_cls;
    logic signed [32:0]   r_diff;
    logic signed [PW-1:0] r_pe;
    logic signed [31:0]   r_res;
    logic                 r_rdone;
    logic                 r_ovalid;
    logic signed [31:0]   r_oval;
    logic                 r_odone;

    // divider hook-up
    logic            n_div_start;
    logic [CW-1:0]   n_den;
    logic [DW-1:0]   n_dividend;
    logic            w_div_done;
    logic [DW-1:0]   w_quot;
    logic signed [65:0] n_qs;

    assign n_div_start = (i_cmd.step == psi_pkg::S_FDS) || (i_cmd.step == psi_pkg::S_BDS);
    assign n_den       = (i_cmd.step == psi_pkg::S_FDS) ? CW'(r_k + CW'(2)) : CW'(r_k + CW'(1));
    assign n_dividend  = DW'(r_num) + DW'(n_den >> 1);
    assign n_qs        = r_neg ? -$signed(66'(w_quot)) : $signed(66'(w_quot));

    psi_div #(
        .DW (DW),
        .NW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_den),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // combinational helpers
    logic               n_first;
    logic               n_last;
    logic [CW-1:0]      n_km1;
    logic signed [31:0] n_t1;
    logic signed [31:0] n_t2;
    logic signed [31:0] n_fwd;
    logic signed [31:0] n_bwd;
    logic [32:0]        n_magv;
    logic [31:0]        n_magp;
    logic [32:0]        n_magz;
    logic [65:0]        n_h2r;
    logic               n_load;

    assign n_first = (r_k == '0);
    assign n_last  = (r_k == CW'(n_m - CW'(1)));
    assign n_km1   = CW'(r_k - CW'(1));
    assign n_t1    = sat32(66'(r_d) - (n_first ? 66'(r_bl) : 66'sd0));
    assign n_t2    = sat32(66'(n_t1) - (n_last ? 66'(r_br) : 66'sd0));
    assign n_fwd   = sat32(-n_qs);
    assign n_bwd   = sat32(66'(r_a) + n_qs);
    assign n_magv  = r_v[32] ? 33'(-r_v) : 33'(r_v);
    assign n_magp  = r_prev[31] ? 32'(-r_prev) : 32'(r_prev);
    assign n_magz  = r_zz[32] ? 33'(-r_zz) : 33'(r_zz);
    assign n_h2r   = (66'(r_h2p) + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign n_load  = i_cmd.accept && (i_command == psi_pkg::CMD_LOAD) &&
                     (32'(i_sample_index) < 32'(MAX_NODES));

    // cell index and fraction of an evaluate position
    logic [2*FRAC_BITS-1:0] n_lo;
    logic [2*FRAC_BITS-1:0] n_nlo;
    logic [HW-1:0]          n_hi;
    logic [65:0]            n_up;
    logic [65:0]            n_pidx;
    logic [65:0]            n_m66;
    logic [FRAC_BITS-1:0]   n_frac;
    psi_pkg::t_cls          n_cls;

    always_comb begin
        n_lo   = r_pm[2*FRAC_BITS-1:0];
        n_nlo  = (2*FRAC_BITS)'(-n_lo);
        n_hi   = r_pm[63:2*FRAC_BITS];
        n_up   = 66'(n_hi) + 66'(n_lo != '0);
        n_pidx = r_zneg ? 66'd0 : 66'(n_hi);
        n_m66  = 66'(n_m);
        n_frac = r_zneg ? n_nlo[2*FRAC_BITS-1:FRAC_BITS] : n_lo[2*FRAC_BITS-1:FRAC_BITS];
        if (r_zneg && n_up >= 66'd2) begin
            n_cls = psi_pkg::CLS_LEFT;
        end else if (r_zneg && n_up == 66'd1) begin
            n_cls = psi_pkg::CLS_NODE;
        end else if (n_pidx >= n_m66) begin
            n_cls = psi_pkg::CLS_RIGHT;
        end else if (n_pidx == n_m66 - 66'd1) begin
            n_cls = psi_pkg::CLS_NODE;
        end else begin
            n_cls = psi_pkg::CLS_INTERP;
        end
    end

    // memory port selection
    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_k[AW-1:0];
        n_wdata = n_fwd;
        case (i_cmd.step)
            psi_pkg::S_BRD: n_raddr = n_km1[AW-1:0];
            psi_pkg::S_ERA: n_raddr = r_idx;
            psi_pkg::S_ERB: n_raddr = AW'(r_idx + AW'(1));
            default:        n_raddr = r_k[AW-1:0];
        endcase
        if (n_load) begin
            n_we    = 1'b1;
            n_waddr = AW'(i_sample_index);
            n_wdata = i_sample_value;
        end else if (i_cmd.step == psi_pkg::S_FW) begin
            n_we = 1'b1;
        end else if (i_cmd.step == psi_pkg::S_BW) begin
            n_we    = 1'b1;
            n_waddr = n_km1[AW-1:0];
            n_wdata = n_bwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_z <= i_query_position;
        case (i_cmd.step)
            psi_pkg::S_H2M:  r_h2p <= 62'(r_grid) * 62'(r_grid);
            psi_pkg::S_H2R: begin
                r_h2   <= (n_h2r > 66'd2147483647) ? 31'h7fffffff : n_h2r[30:0];
                r_k    <= '0;
                r_prev <= '0;
            end
            psi_pkg::S_FMUL: r_p <= $signed({1'b0, r_h2}) * r_rdata;
            psi_pkg::S_FD:   r_d <= sat32(shr_round(66'(r_p)));
            psi_pkg::S_FB:   r_d <= n_t2;
            psi_pkg::S_FV:   r_v <= 33'(r_d) - 33'(r_prev);
            psi_pkg::S_FN: begin
                r_num <= NUMW'(n_magv) * NUMW'(CW'(r_k + CW'(1)));
                r_neg <= r_v[32];
            end
            psi_pkg::S_FW: begin
                r_prev <= n_fwd;
                if (!n_last) r_k <= CW'(r_k + CW'(1));
            end
            psi_pkg::S_BN: begin
                r_a   <= r_rdata;
                r_num <= NUMW'(n_magp) * NUMW'(r_k);
                r_neg <= r_prev[31];
            end
            psi_pkg::S_BW: begin
                r_prev  <= n_bwd;
                r_k     <= n_km1;
                r_res   <= '0;
                r_rdone <= 1'b1;
            end
            psi_pkg::S_ES: begin
                r_zz    <= 33'(r_z) - 33'(r_ds);
                r_rdone <= 1'b0;
            end
            psi_pkg::S_EM: begin
                r_pm   <= 64'(n_magz) * 64'(r_inv);
                r_zneg <= r_zz[32];
            end
            psi_pkg::S_EI: begin
                r_cls  <= n_cls;
                r_idx  <= n_pidx[AW-1:0];
                r_frac <= n_frac;
                r_res  <= (n_cls == psi_pkg::CLS_LEFT) ? r_bl : r_br;
            end
            psi_pkg::S_ERB:  r_a <= r_rdata;
            psi_pkg::S_ED: begin
                r_res  <= r_a;
                r_diff <= 33'(r_rdata) - 33'(r_a);
            end
            psi_pkg::S_EP:   r_pe  <= r_diff * $signed({1'b0, r_frac});
            psi_pkg::S_EF:   r_res <= sat32(66'(r_a) + shr_round(66'(r_pe)));
            default: ;
        endcase
    end

    // result register: hold until taken
    logic n_out_free;
    assign n_out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.step == psi_pkg::S_OUT && n_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step == psi_pkg::S_OUT && n_out_free) begin
            r_oval  <= r_res;
            r_odone <= r_rdone;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_result_value  = r_oval;
    assign o_solve_done    = r_odone;
    assign o_stat.k_last   = n_last;
    assign o_stat.k_one    = (r_k == CW'(1));
    assign o_stat.div_done = w_div_done;
    assign o_stat.cls      = (i_cmd.step == psi_pkg::S_EI) ? n_cls : r_cls;
    assign o_stat.out_free = n_out_free;
endmodule

// ===== design/poisson_1d_solver_interpolator.sv =====
`timescale 1ns / 1ps

// One-dimensional Poisson solver with interpolating read-out, signed Q16.16.
// A load request writes one right-hand-side sample as it is taken and
// returns nothing. An evaluate request passes S_ES, S_EM and S_EI and then
// registers the boundary value for a position off the grid; an edge node
// adds S_ERA, S_ERB and S_ED, and the linear interpolation of two nodes adds
// S_EP and S_EF as well. A solve request runs a forward and a back Thomas
// sweep over the M interior nodes in place; each node step waits on the
// shared restoring divider (a DW = 34 + clog2(MAX_NODES+2) bit quotient, 45
// by default), and then the solve returns a zero result flagged solve_done.
// Requests are taken one at a time, only in S_IDLE, which the controller
// re-enters as the result is registered; a result waits in the output
// register while the next request runs. Node entries read by solve or
// evaluate must have been loaded first.
module poisson_1d_solver_interpolator #(
    parameter int MAX_NODES = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [psi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    psi_req_if.sink                        i_req,
    psi_res_if.source                      o_res
);
    psi_pkg::t_cmd  w_cmd;
    psi_pkg::t_stat w_stat;

    psi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req.valid),
        .i_command (i_req.command),
        .i_stat    (w_stat),
        .o_ready   (i_req.ready),
        .o_cmd     (w_cmd)
    );

    psi_dp #(
        .MAX_NODES (MAX_NODES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_req.command),
        .i_sample_index   (i_req.sample_index),
        .i_sample_value   (i_req.sample_value),
        .i_query_position (i_req.query_position),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_result_value   (o_res.result_value),
        .o_solve_done     (o_res.solve_done),
        .o_stat           (w_stat)
    );
endmodule

// ===== design/psi_chk.sv =====
`timescale 1ns / 1ps

module psi_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_result_value,
    input logic        i_solve_done
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_result_value) && $stable(i_solve_done))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    a_solve_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_solve_done |-> i_result_value == 32'd0)
        else $error("solve result carries a value");
endmodule

bind poisson_1d_solver_interpolator psi_chk u_psi_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_result_value (o_res.result_value),
    .i_solve_done   (o_res.solve_done)
);

// ===== verif/psi_checker.sv =====
`timescale 1ns / 1ps

module psi_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [psi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    psi_req_if                             i_req,
    psi_res_if                             i_res,
    output int                             o_fail_count,
    output int                             o_pending
);
    localparam int NODES = 1024;
    localparam int FB    = 16;

    typedef struct {
        logic signed [31:0] value;
        logic               done;
    } t_result;

    bit [30:0]          step_q, inv_step_q;
    logic signed [31:0] left_q, right_q, origin_q;
    bit [10:0]          count_q;
    logic signed [31:0] potential[NODES];
    t_result            expected_q[$];

    initial begin
        o_fail_count = 0;
        for (int k = 0; k < NODES; k++) potential[k] = '0;
    end

    assign o_pending = expected_q.size();

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint shift_round(longint v, int s);
        bit [63:0] m;
        m = (magnitude(v) + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint scale_round(longint v, bit [63:0] num, bit [63:0] den);
        bit [63:0] m;
        m = (magnitude(v) * num + den / 2) / den;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic int nodes_in_use();
        if (count_q < 2) return 2;
        if (count_q > NODES) return NODES;
        return count_q;
    endfunction

    // forward then back Thomas sweep, in place
    task automatic solve_nodes();
        int        m;
        bit [63:0] sq;
        longint    h2, carry, d;
        m     = nodes_in_use();
        sq    = 64'(step_q) * 64'(step_q);
        h2    = shift_round(longint'(sq), FB);
        carry = 0;
        if (h2 > 64'sd2147483647) h2 = 64'sd2147483647;
        for (int k = 0; k < m; k++) begin
            d = clamp32(shift_round(h2 * longint'(potential[k]), FB));
            if (k == 0) d = clamp32(d - longint'(left_q));
            if (k == m - 1) d = clamp32(d - longint'(right_q));
            carry = clamp32(-scale_round(d - carry, k + 1, k + 2));
            potential[k] = carry[31:0];
        end
        for (int k = m - 1; k > 0; k--)
            potential[k-1] = clamp32(longint'(potential[k-1]) +
                scale_round(longint'(potential[k]), k, k + 1));
    endtask

    function automatic logic signed [31:0] interpolate(logic signed [31:0] z);
        longint    m, zz, slot, a, b;
        bit [63:0] prod, mask, up, frac;
        m    = nodes_in_use();
        zz   = longint'(z) - longint'(origin_q);
        prod = magnitude(zz) * 64'(inv_step_q);
        mask = (64'd1 << (2 * FB)) - 1;
        if (zz < 0) begin
            up   = (prod + mask) >> (2 * FB);
            slot = -longint'(up);
            frac = ((64'd0 - prod) & mask) >> FB;
        end else begin
            slot = longint'(prod >> (2 * FB));
            frac = (prod & mask) >> FB;
        end
        if (slot < -1) return left_q;
        if (slot >= m) return right_q;
        if (slot == -1) return potential[0];
        if (slot == m - 1) return potential[slot];
        a = potential[slot];
        b = potential[slot+1];
        return clamp32(a + shift_round((b - a) * longint'(frac), FB));
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_q     <= 31'd65536;
            inv_step_q <= 31'd65536;
            left_q     <= '0;
            right_q    <= '0;
            origin_q   <= '0;
            count_q    <= 11'd1024;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    psi_pkg::REG_GRID_STEP:      step_q     <= i_cfg_data[30:0];
                    psi_pkg::REG_INV_GRID_STEP:  inv_step_q <= i_cfg_data[30:0];
                    psi_pkg::REG_BOUNDARY_LEFT:  left_q     <= i_cfg_data;
                    psi_pkg::REG_BOUNDARY_RIGHT: right_q    <= i_cfg_data;
                    psi_pkg::REG_DOMAIN_START:   origin_q   <= i_cfg_data;
                    psi_pkg::REG_INTERIOR_COUNT: count_q    <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result", i_res.result_value, 0);
                end else begin
                    t_result e;
                    e = expected_q.pop_front();
                    if (i_res.result_value !== e.value)
                        report("result_value", i_res.result_value, e.value);
                    if (i_res.solve_done !== e.done)
                        report("solve_done", i_res.solve_done, e.done);
                end
            end
            if (i_req.valid && i_req.ready) begin
                case (i_req.command)
                    psi_pkg::CMD_LOAD:  potential[i_req.sample_index] = i_req.sample_value;
                    psi_pkg::CMD_SOLVE: begin
                        solve_nodes();
                        expected_q.push_back('{value: '0, done: 1'b1});
                    end
                    psi_pkg::CMD_EVAL:
                        expected_q.push_back('{value: interpolate(i_req.query_position),
                                               done: 1'b0});
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== verif/poisson_1d_solver_interpolator_tb.sv =====
`timescale 1ns / 1ps

module poisson_1d_solver_interpolator_tb;
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [psi_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [psi_pkg::CFG_DATA_W-1:0] i_cfg_data;
    int                             fail_count;
    int                             pending;
    bit                             idle_on;
    int                             active_nodes;
    logic signed [31:0]             origin;
    bit [30:0]                      inv_step;

    psi_req_if req ();
    psi_res_if res ();

    poisson_1d_solver_interpolator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req), .o_res(res)
    );

    psi_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req), .i_res(res),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall before each result while idle_on is set
    initial begin
        int stall;
        res.ready = 1'b0;
        forever begin
            stall = idle_on ? $urandom_range(0, 16) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                res.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res.ready = 1'b1;
            do @(posedge i_clk); while (!res.valid);
        end
    end

    task automatic send(logic [1:0] cmd, logic [9:0] idx, logic [31:0] val,
                        logic [31:0] pos);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.command        = cmd;
        req.sample_index   = idx;
        req.sample_value   = val;
        req.query_position = pos;
        req.valid          = 1'b1;
        do @(posedge i_clk); while (!req.ready);
    endtask

    // hold until every result is back, then let the last load settle
    task automatic drain();
        @(negedge i_clk);
        req.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [psi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic configure(bit [30:0] h, bit [30:0] inv_h, logic [31:0] left,
                             logic [31:0] right, logic [31:0] start, bit [10:0] count);
        drain();
        write_reg(psi_pkg::REG_GRID_STEP, 32'(h));
        write_reg(psi_pkg::REG_INV_GRID_STEP, 32'(inv_h));
        write_reg(psi_pkg::REG_BOUNDARY_LEFT, left);
        write_reg(psi_pkg::REG_BOUNDARY_RIGHT, right);
        write_reg(psi_pkg::REG_DOMAIN_START, start);
        write_reg(psi_pkg::REG_INTERIOR_COUNT, 32'(count));
        active_nodes = count < 2 ? 2 : (count > 1024 ? 1024 : count);
        origin       = start;
        inv_step     = inv_h;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        endcase
    endfunction

    // position mostly around the grid, in cell units, mapped through 1/h
    function automatic logic [31:0] rand_position();
        longint cells, zz;
        if ($urandom_range(0, 4) == 0) return $urandom();
        cells = longint'($urandom_range(0, (active_nodes + 4) * 256)) * 256 - (2 << 16);
        zz    = (cells <<< 16) / (inv_step == 0 ? 1 : inv_step);
        return 32'(longint'(origin) + zz);
    endfunction

    task automatic load_grid();
        for (int k = 0; k < active_nodes; k++) send(psi_pkg::CMD_LOAD, k, rand_sample(), '0);
    endtask

    task automatic random_mix(int n, int solve_odds);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < solve_odds)
                send(psi_pkg::CMD_SOLVE, $urandom(), $urandom(), $urandom());
            else if (r < 70)
                send(psi_pkg::CMD_EVAL, $urandom(), $urandom(), rand_position());
            else if (r < 95)
                send(psi_pkg::CMD_LOAD,
                     $urandom_range(0, 1) ? $urandom_range(0, active_nodes - 1)
                                          : $urandom_range(0, 1023),
                     rand_sample(), $urandom());
            else
                send(psi_pkg::CMD_RSVD, $urandom(), $urandom(), $urandom());
        end
    endtask

    initial begin
        bit [30:0] h;
        req.valid = 1'b0;
        req.command = psi_pkg::CMD_LOAD;
        req.sample_index = '0;
        req.sample_value = '0;
        req.query_position = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        idle_on = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: saturating samples, edge cells, unknown command, far positions
        configure(31'd65536, 31'd65536, 32'h8000_0000, 32'h7fff_ffff, '0, 11'd4);
        send(psi_pkg::CMD_LOAD, 10'd0, 32'h7fff_ffff, '0);
        send(psi_pkg::CMD_LOAD, 10'd1, 32'h8000_0000, '0);
        send(psi_pkg::CMD_LOAD, 10'd2, 32'h0001_0000, '0);
        send(psi_pkg::CMD_LOAD, 10'd3, 32'hffff_0000, '0);
        send(psi_pkg::CMD_LOAD, 10'd1023, 32'h1234_5678, '0);
        send(psi_pkg::CMD_RSVD, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff);
        send(psi_pkg::CMD_EVAL, '0, '0, 32'h0001_8000);
        send(psi_pkg::CMD_EVAL, '0, '0, 32'hffff_8000);
        send(psi_pkg::CMD_EVAL, '0, '0, 32'hfffe_0000);
        send(psi_pkg::CMD_EVAL, '0, '0, 32'h0003_4000);
        send(psi_pkg::CMD_EVAL, '0, '0, 32'h0004_0000);
        send(psi_pkg::CMD_EVAL, '0, '0, 32'h8000_0000);
        send(psi_pkg::CMD_EVAL, '0, '0, 32'h7fff_ffff);
        send(psi_pkg::CMD_SOLVE, '0, '0, '0);
        send(psi_pkg::CMD_EVAL, '0, '0, 32'h0000_8000);
        send(psi_pkg::CMD_EVAL, '0, '0, 32'h0002_c000);

        configure(31'h7fff_ffff, 31'd1, $urandom(), $urandom(), 32'h8000_0000, 11'd0);
        idle_on = 1'b1;
        load_grid();
        random_mix(50, 6);

        configure(31'd1, 31'h7fff_ffff, $urandom(), $urandom(), 32'h7fff_ffff, 11'd1);
        idle_on = 1'b0;
        load_grid();
        random_mix(50, 6);

        for (int p = 0; p < 6; p++) begin
            h = $urandom_range(6554, 262144);
            configure(h, 31'((64'd1 << 32) / h),
                      32'($signed($urandom_range(0, 200 << 16)) - (100 << 16)),
                      32'($signed($urandom_range(0, 200 << 16)) - (100 << 16)),
                      32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16)),
                      $urandom_range(2, 20));
            idle_on = p[0];
            load_grid();
            random_mix(120, 5);
        end

        // full grid with an oversized count, one long solve
        configure(31'd655, 31'd6553600, 32'h0002_0000, 32'hfffd_0000, 32'hfff0_0000,
                  11'd2047);
        idle_on = 1'b1;
        load_grid();
        send(psi_pkg::CMD_SOLVE, '0, '0, '0);
        random_mix(40, 0);

        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/psi_pkg.sv
design/psi_if.sv
design/psi_div.sv
design/psi_ctrl.sv
design/psi_dp.sv
design/poisson_1d_solver_interpolator.sv
design/psi_chk.sv
verif/psi_checker.sv
verif/poisson_1d_solver_interpolator_tb.sv
